### rtl/core/pcsp_pkg.sv
`default_nettype none
package pcsp_pkg;

	// most prefetch addresses issued for one access
	localparam logic [4:0] MAX_RESULTS = 5'd16;

	// LFSR seed after reset
	localparam logic [15:0] LFSR_SEED = 16'hACE1;

	// configuration register indexes
	localparam logic [2:0] REG_USE_CONTEXT = 3'd0;
	localparam logic [2:0] REG_CONF_MAX    = 3'd1;
	localparam logic [2:0] REG_CONF_THR    = 3'd2;
	localparam logic [2:0] REG_CONF_MIN    = 3'd3;
	localparam logic [2:0] REG_CONF_START  = 3'd4;
	localparam logic [2:0] REG_DEGREE      = 3'd5;

	typedef struct packed {
		logic       use_context;
		logic [3:0] conf_max;
		logic [3:0] conf_threshold;
		logic [3:0] conf_min;
		logic [3:0] conf_start;
		logic [4:0] prefetch_degree;
	} cfg_t;

	// one table entry as held in the table memory
	typedef struct packed {
		logic        valid;
		logic [47:0] tag_pc;
		logic        secure;
		logic [47:0] last_addr;
		logic [31:0] stride;
		logic [3:0]  confidence;
	} entry_t;

	localparam int ENTRY_W = $bits(entry_t);

endpackage
`default_nettype wire

### rtl/core/pcsp_ram.sv
`default_nettype none
module pcsp_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  wire                               clk,
	input  wire                               we,
	input  wire  [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  wire  [WIDTH-1:0]                  wdata,
	input  wire  [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                  rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// write one word, register the read word
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule
`default_nettype wire

### rtl/core/pcsp_cfg.sv
`default_nettype none
module pcsp_cfg (
	input  wire              clk,
	input  wire              arst_n,
	input  wire              cfg_we,
	input  wire  [2:0]       cfg_index,
	input  wire  [4:0]       cfg_wdata,
	output pcsp_pkg::cfg_t   cfg
);
	import pcsp_pkg::*;

	cfg_t cfg_q;

	// decode the write and update one field; unknown indexes drop the write
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.use_context     <= 1'b0;
			cfg_q.conf_max        <= 4'd7;
			cfg_q.conf_threshold  <= 4'd4;
			cfg_q.conf_min        <= 4'd0;
			cfg_q.conf_start      <= 4'd4;
			cfg_q.prefetch_degree <= 5'd4;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_USE_CONTEXT: cfg_q.use_context     <= cfg_wdata[0];
				REG_CONF_MAX:    cfg_q.conf_max        <= cfg_wdata[3:0];
				REG_CONF_THR:    cfg_q.conf_threshold  <= cfg_wdata[3:0];
				REG_CONF_MIN:    cfg_q.conf_min        <= cfg_wdata[3:0];
				REG_CONF_START:  cfg_q.conf_start      <= cfg_wdata[3:0];
				REG_DEGREE:      cfg_q.prefetch_degree <= cfg_wdata;
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule
`default_nettype wire

### rtl/core/pc_stride_prefetcher.sv
`default_nettype none
// PC-indexed stride prefetcher. An access is taken in the idle state. An access without a pc
// needs nothing more. Otherwise the ways of its set are probed one after another through a
// single-port-read table memory, each way by a look state and a check state, stopping at the
// hit. On a miss, the victim state divides the 16-bit LFSR by WAYS with a reciprocal multiply
// and the miss state writes the victim. On a hit, the update state writes the entry. When the
// access issues, the step state forms the step, then the shared adder forms one prefetch
// address per cycle while the output side does not stall, and a closing step sends the last.
// After reset a clearing pass writes every one of the CONTEXTS*SETS*WAYS entries to empty the
// table. No access is taken during the pass, but configuration writes are.
module pc_stride_prefetcher #(
	parameter int SETS        = 64,
	parameter int WAYS        = 4,
	parameter int CONTEXTS    = 4,
	parameter int BLOCK_BYTES = 64,
	parameter int PAGE_BYTES  = 4096,
	parameter int ADDR_BITS   = 48
) (
	input  wire         clk,
	input  wire         arst_n,
	input  wire         cfg_we,
	input  wire  [2:0]  cfg_index,
	input  wire  [4:0]  cfg_wdata,
	input  wire         s_tvalid,
	output logic        s_tready,
	input  wire  [95:0] s_tdata,   // pc[47:0], access_addr[95:48]
	input  wire  [3:0]  s_tuser,   // has_pc[0], secure[1], context_id[3:2]
	output logic        m_tvalid,
	input  wire         m_tready,
	output logic [47:0] m_tdata,   // prefetch_addr[47:0]
	output logic        m_tlast
);
	import pcsp_pkg::*;

	localparam int NENT = CONTEXTS * SETS * WAYS;
	localparam int IW   = NENT > 1 ? $clog2(NENT) : 1;
	localparam int LG   = $clog2(SETS);
	localparam int SIW  = SETS > 1 ? LG : 1;
	localparam int WW   = WAYS > 1 ? $clog2(WAYS) : 1;
	localparam int VS   = 20;
	localparam logic [20:0] RECIP = 21'(((64'd1 << VS) + 64'(WAYS) - 64'd1) / 64'(WAYS));
	localparam int AW   = ADDR_BITS;
	localparam logic [63:0] PMASK = ~(64'(PAGE_BYTES) - 64'd1);
	localparam logic [63:0] BLK   = 64'(BLOCK_BYTES);

	typedef enum logic [8:0] {
		ST_CLR  = 9'b000000001,
		ST_IDLE = 9'b000000010,
		ST_LOOK = 9'b000000100,
		ST_CHK  = 9'b000001000,
		ST_VICT = 9'b000010000,
		ST_MISS = 9'b000100000,
		ST_UPD  = 9'b001000000,
		ST_STEP = 9'b010000000,
		ST_ADV  = 9'b100000000
	} state_t;

	function automatic logic [1:0] ctx_reduce(input logic [1:0] c);
		logic [4:0] v;
		v = {3'b000, c};
		if (v >= 5'(CONTEXTS)) v = v - 5'(CONTEXTS);
		if (v >= 5'(CONTEXTS)) v = v - 5'(CONTEXTS);
		if (v >= 5'(CONTEXTS)) v = v - 5'(CONTEXTS);
		return v[1:0];
	endfunction

	cfg_t cfg;

	pcsp_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.cfg       (cfg)
	);

	state_t          state_q;
	logic [IW-1:0]   clr_q;
	logic [47:0]     pc_q;
	logic [47:0]     addr_q;
	logic            sec_q;
	logic [IW-1:0]   base_q;
	logic [WW-1:0]   way_q;
	logic [15:0]     lfsr_q;
	logic [15:0]     vq_q;
	entry_t          ent_q;
	logic [31:0]     ns_q;
	logic [AW-1:0]   step_q;
	logic [AW-1:0]   na_q;
	logic [AW-1:0]   pend_q;
	logic            pend_v_q;
	logic [4:0]      d_q;
	logic            m_tvalid_q;
	logic [47:0]     m_tdata_q;
	logic            m_tlast_q;

	logic [ENTRY_W-1:0] rdata;
	entry_t          rd_ent;
	entry_t          wr_ent;
	logic            we;
	logic [IW-1:0]   waddr;
	logic [IW-1:0]   raddr;

	// hash the pc into a set and form the row base of the selected table copy
	logic [46:0]     h1;
	logic [SIW-1:0]  set_idx;
	logic [1:0]      ctx;
	logic [IW-1:0]   base_d;
	always_comb begin
		h1      = s_tdata[47:1];
		set_idx = SIW'(h1 ^ (h1 >> LG)) & SIW'(SETS - 1);
		ctx     = cfg.use_context ? ctx_reduce(s_tuser[3:2]) : 2'd0;
		base_d  = IW'((int'(ctx) * SETS + int'(set_idx)) * WAYS);
	end

	assign raddr  = IW'(base_q + IW'(way_q));
	assign rd_ent = entry_t'(rdata);

	logic hit;
	assign hit = rd_ent.valid && (rd_ent.tag_pc == pc_q) && (rd_ent.secure == sec_q);

	// confidence and stride update of a hit entry
	logic [47:0] diff;
	logic [31:0] ns;
	logic [3:0]  conf_n;
	logic [31:0] stride_n;
	logic [4:0]  deg;
	always_comb begin
		diff     = addr_q - ent_q.last_addr;
		ns       = diff[31:0];
		conf_n   = ent_q.confidence;
		stride_n = ent_q.stride;
		if ((ns == ent_q.stride) && (ns != 32'd0)) begin
			if (conf_n < cfg.conf_max) conf_n = conf_n + 4'd1;
		end else begin
			if (conf_n > cfg.conf_min) conf_n = conf_n - 4'd1;
			if (conf_n < cfg.conf_threshold) stride_n = ns;
		end
		deg = (cfg.prefetch_degree > MAX_RESULTS) ? MAX_RESULTS : cfg.prefetch_degree;
	end

	// round the stride up to one block in magnitude
	logic [31:0] mag;
	logic [AW-1:0] step_d;
	always_comb begin
		mag = ns_q[31] ? 32'd0 - ns_q : ns_q;
		if (mag < 32'(BLOCK_BYTES)) begin
			step_d = AW'(ns_q[31] ? 64'd0 - BLK : BLK);
		end else begin
			step_d = AW'({{32{ns_q[31]}}, ns_q});
		end
	end

	// shared adder for the next candidate and its page check
	logic [AW-1:0] addrw;
	logic [AW-1:0] cand;
	logic          cand_ok;
	logic          push_ok;
	logic          push_now;
	assign addrw    = AW'(64'(addr_q));
	assign cand     = na_q + step_q;
	assign cand_ok  = (d_q < deg) && (((64'(cand) ^ 64'(addr_q)) & PMASK) == 64'd0);
	assign push_ok  = !m_tvalid_q || m_tready;
	assign push_now = (state_q == ST_ADV) && pend_v_q && push_ok;

	// victim way: LFSR modulo WAYS by reciprocal multiplication
	logic [36:0] vprod;
	logic [15:0] vrem;
	assign vprod = 37'(lfsr_q) * 37'(RECIP);
	assign vrem  = lfsr_q - 16'(vq_q * 16'(WAYS));

	// table write port
	always_comb begin
		we     = 1'b0;
		waddr  = raddr;
		wr_ent = ent_q;
		unique case (state_q)
			ST_CLR: begin
				we     = 1'b1;
				waddr  = clr_q;
				wr_ent = '0;
			end
			ST_MISS: begin
				we                = 1'b1;
				waddr             = IW'(base_q + IW'(vrem[WW-1:0]));
				wr_ent.valid      = 1'b1;
				wr_ent.tag_pc     = pc_q;
				wr_ent.secure     = sec_q;
				wr_ent.last_addr  = addr_q;
				wr_ent.stride     = 32'd0;
				wr_ent.confidence = cfg.conf_start;
			end
			ST_UPD: begin
				we                = 1'b1;
				wr_ent.last_addr  = addr_q;
				wr_ent.stride     = stride_n;
				wr_ent.confidence = conf_n;
			end
			default: ;
		endcase
	end

	pcsp_ram #(
		.WIDTH (ENTRY_W),
		.DEPTH (NENT)
	) u_ram (
		.clk   (clk),
		.we    (we),
		.waddr (waddr),
		.wdata (wr_ent),
		.raddr (raddr),
		.rdata (rdata)
	);

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_CLR;
			clr_q      <= '0;
			lfsr_q     <= LFSR_SEED;
			pend_v_q   <= 1'b0;
			m_tvalid_q <= 1'b0;
		end else begin
			// raise the output on a new transfer, drop it once taken
			if (push_now) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tvalid_q && m_tready) begin
				m_tvalid_q <= 1'b0;
			end
			unique case (state_q)
				ST_CLR: begin
					clr_q <= IW'(clr_q + IW'(1));
					if (clr_q == IW'(NENT - 1)) state_q <= ST_IDLE;
				end
				ST_IDLE: begin
					if (s_tvalid) begin
						pc_q   <= s_tdata[47:0];
						addr_q <= s_tdata[95:48];
						sec_q  <= s_tuser[1];
						base_q <= base_d;
						way_q  <= '0;
						if (s_tuser[0]) state_q <= ST_LOOK;
					end
				end
				ST_LOOK: state_q <= ST_CHK;
				ST_CHK: begin
					ent_q <= rd_ent;
					if (hit) begin
						state_q <= ST_UPD;
					end else if (way_q == WW'(WAYS - 1)) begin
						state_q <= ST_VICT;
					end else begin
						way_q   <= WW'(way_q + WW'(1));
						state_q <= ST_LOOK;
					end
				end
				ST_VICT: begin
					vq_q    <= vprod[35:20];
					state_q <= ST_MISS;
				end
				ST_MISS: begin
					lfsr_q  <= {lfsr_q[0] ^ lfsr_q[2] ^ lfsr_q[3] ^ lfsr_q[5], lfsr_q[15:1]};
					state_q <= ST_IDLE;
				end
				ST_UPD: begin
					ns_q <= ns;
					if ((conf_n >= cfg.conf_threshold) && (deg != 5'd0)) begin
						state_q <= ST_STEP;
					end else begin
						state_q <= ST_IDLE;
					end
				end
				ST_STEP: begin
					step_q   <= step_d;
					na_q     <= addrw;
					d_q      <= 5'd0;
					pend_v_q <= 1'b0;
					state_q  <= ST_ADV;
				end
				ST_ADV: begin
					if (cand_ok) begin
						if (!pend_v_q || push_ok) begin
							if (pend_v_q) begin
								m_tdata_q <= 48'(64'(pend_q));
								m_tlast_q <= 1'b0;
							end
							pend_q   <= cand;
							pend_v_q <= 1'b1;
							na_q     <= cand;
							d_q      <= d_q + 5'd1;
						end
					end else if (!pend_v_q) begin
						state_q <= ST_IDLE;
					end else if (push_ok) begin
						m_tdata_q  <= 48'(64'(pend_q));
						m_tlast_q  <= 1'b1;
						pend_v_q   <= 1'b0;
						state_q    <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign s_tready = (state_q == ST_IDLE);
	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;
	assign m_tlast  = m_tlast_q;

`ifndef SYNTH
	// table is written only by the sequencer's busy states
	assert property (@(posedge clk) disable iff (!arst_n) we |-> (state_q != ST_IDLE))
		else $error("table write while idle");
	// no access taken during the clearing pass
	assert property (@(posedge clk) disable iff (!arst_n) (state_q == ST_CLR) |-> !s_tready)
		else $error("access accepted during clear");
	// victim way stays inside the set
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_MISS) |-> (vrem < 16'(WAYS)))
		else $error("victim way out of range");
	// a held prefetch only waits while emission is running
	assert property (@(posedge clk) disable iff (!arst_n) pend_v_q |-> (state_q == ST_ADV))
		else $error("pending prefetch outside emission");
`endif

endmodule
`default_nettype wire
